[sv/assert_macros.svh]
// Assertion macros shared by the checker of the Metropolis lattice block.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define IML_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define IML_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error(msg);

`endif

[sv/iml_pkg.sv]
// Package of the Metropolis lattice block: field widths, request kinds and
// the command and status types between controller and datapath. No dependencies.
`default_nettype none

package iml_pkg;

   localparam int DEFAULT_LATTICE_SIDE = 64;

   localparam int KIND_W      = 2;
   localparam int ROW_W       = 6;
   localparam int RND_W       = 32;
   localparam int THRESH_W    = 33;
   localparam int ENERGY_W    = 15;
   localparam int MOMENT_W    = 14;
   localparam int ACC_CNT_W   = 48;
   localparam int SWEEP_CNT_W = 32;
   localparam int SUM_E_W     = 46;
   localparam int SUM_E2_W    = 58;
   localparam int SUM_M_W     = 45;
   localparam int SUM_M2_W    = 56;
   localparam int SUM_AM_W    = 44;
   localparam int E2_W        = 2 * ENERGY_W - 1;
   localparam int M2_W        = 2 * MOMENT_W - 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   typedef logic [KIND_W-1:0] iml_kind_type;
   localparam iml_kind_type KIND_LOAD  = 2'd0;
   localparam iml_kind_type KIND_START = 2'd1;
   localparam iml_kind_type KIND_FLIP  = 2'd2;
   localparam iml_kind_type KIND_SWEEP = 2'd3;

   typedef logic iml_reg_idx_type;
   localparam iml_reg_idx_type REG_TH4 = 1'b0;
   localparam iml_reg_idx_type REG_TH8 = 1'b1;

   typedef logic [2:0] iml_addr_sel_type;
   localparam iml_addr_sel_type ADR_SITE  = 3'd0;
   localparam iml_addr_sel_type ADR_RIGHT = 3'd1;
   localparam iml_addr_sel_type ADR_DOWN  = 3'd2;
   localparam iml_addr_sel_type ADR_LEFT  = 3'd3;
   localparam iml_addr_sel_type ADR_UP    = 3'd4;

   typedef logic [2:0] iml_tag_type;
   localparam iml_tag_type TAG_NONE = 3'd0;
   localparam iml_tag_type TAG_SITE = 3'd1;
   localparam iml_tag_type TAG_PAIR = 3'd2;
   localparam iml_tag_type TAG_BOND = 3'd3;
   localparam iml_tag_type TAG_NBR  = 3'd4;

   typedef logic [1:0] iml_wr_sel_type;
   localparam iml_wr_sel_type WR_ONE  = 2'd0;
   localparam iml_wr_sel_type WR_LOAD = 2'd1;
   localparam iml_wr_sel_type WR_FLIP = 2'd2;

   typedef struct packed {
      iml_addr_sel_type addr_sel;
      iml_tag_type      tag;
      logic             wr_en;
      iml_wr_sel_type   wr_sel;
      logic             cursor_step;
      logic             latch;
      logic             walk_init;
      logic             flip_commit;
      logic             walk_commit;
      logic             sweep_square;
      logic             sweep_commit;
      logic             respond;
   } iml_cmd_type;

   typedef struct packed {
      logic cursor_last;
   } iml_status_type;

endpackage

`default_nettype wire

[sv/iml_csr.sv]
// Threshold registers of the Metropolis lattice block behind an APB-style port.
// Depends on iml_pkg.
`default_nettype none

module iml_csr import iml_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [THRESH_W-1:0]   threshold_4,
   output logic [THRESH_W-1:0]   threshold_8
);

   logic [THRESH_W-1:0] th4_ff;
   logic [THRESH_W-1:0] th8_ff;
   logic                wr_stb;
   iml_reg_idx_type     reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         th4_ff <= '0;
         th8_ff <= '0;
      end else if (wr_stb) begin
         unique case (reg_idx)
            REG_TH4: th4_ff <= pwdata[THRESH_W-1:0];
            REG_TH8: th8_ff <= pwdata[THRESH_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TH4: prdata = {{(CSR_DATA_W-THRESH_W){1'b0}}, th4_ff};
         REG_TH8: prdata = {{(CSR_DATA_W-THRESH_W){1'b0}}, th8_ff};
      endcase
   end

   assign threshold_4 = th4_ff;
   assign threshold_8 = th8_ff;

endmodule

`default_nettype wire

[sv/iml_ctrl.sv]
// Controller of the Metropolis lattice block: sequences the clearing pass, the
// lattice walk, flip attempts and sweep accumulation. Depends on iml_pkg.
`default_nettype none

module iml_ctrl import iml_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  iml_kind_type   req_kind,
   input  iml_status_type status,
   output iml_cmd_type    cmd,
   output logic           busy
);

   localparam logic [4:0] ST_CLEAR  = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_LOAD   = 5'd2;
   localparam logic [4:0] ST_W_S    = 5'd3;
   localparam logic [4:0] ST_W_R    = 5'd4;
   localparam logic [4:0] ST_W_D    = 5'd5;
   localparam logic [4:0] ST_W_END  = 5'd6;
   localparam logic [4:0] ST_W_FIN  = 5'd7;
   localparam logic [4:0] ST_F_S    = 5'd8;
   localparam logic [4:0] ST_F_R    = 5'd9;
   localparam logic [4:0] ST_F_D    = 5'd10;
   localparam logic [4:0] ST_F_L    = 5'd11;
   localparam logic [4:0] ST_F_U    = 5'd12;
   localparam logic [4:0] ST_F_WAIT = 5'd13;
   localparam logic [4:0] ST_F_DEC  = 5'd14;
   localparam logic [4:0] ST_E_SQ   = 5'd15;
   localparam logic [4:0] ST_E_ACC  = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_ONE;
            cmd.cursor_step = 1'b1;
            if (status.cursor_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_LOAD: begin
                     cmd.latch = 1'b1;
                     state_in  = ST_LOAD;
                  end
                  KIND_START: begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_W_S;
                  end
                  KIND_FLIP: begin
                     cmd.latch = 1'b1;
                     state_in  = ST_F_S;
                  end
                  KIND_SWEEP: begin
                     cmd.latch = 1'b1;
                     state_in  = ST_E_SQ;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_LOAD;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_W_S: begin
            cmd.tag  = TAG_SITE;
            state_in = ST_W_R;
         end
         ST_W_R: begin
            cmd.addr_sel = ADR_RIGHT;
            cmd.tag      = TAG_PAIR;
            state_in     = ST_W_D;
         end
         ST_W_D: begin
            cmd.addr_sel    = ADR_DOWN;
            cmd.tag         = TAG_BOND;
            cmd.cursor_step = 1'b1;
            state_in        = status.cursor_last ? ST_W_END : ST_W_S;
         end
         ST_W_END: begin
            state_in = ST_W_FIN;
         end
         ST_W_FIN: begin
            cmd.walk_commit = 1'b1;
            cmd.respond     = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_F_S: begin
            cmd.tag  = TAG_SITE;
            state_in = ST_F_R;
         end
         ST_F_R: begin
            cmd.addr_sel = ADR_RIGHT;
            cmd.tag      = TAG_NBR;
            state_in     = ST_F_D;
         end
         ST_F_D: begin
            cmd.addr_sel = ADR_DOWN;
            cmd.tag      = TAG_NBR;
            state_in     = ST_F_L;
         end
         ST_F_L: begin
            cmd.addr_sel = ADR_LEFT;
            cmd.tag      = TAG_NBR;
            state_in     = ST_F_U;
         end
         ST_F_U: begin
            cmd.addr_sel = ADR_UP;
            cmd.tag      = TAG_NBR;
            state_in     = ST_F_WAIT;
         end
         ST_F_WAIT: begin
            state_in = ST_F_DEC;
         end
         ST_F_DEC: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_FLIP;
            cmd.flip_commit = 1'b1;
            cmd.respond     = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_E_SQ: begin
            cmd.sweep_square = 1'b1;
            state_in         = ST_E_ACC;
         end
         ST_E_ACC: begin
            cmd.sweep_commit = 1'b1;
            cmd.respond      = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/iml_datapath.sv]
// Datapath of the Metropolis lattice block: spin memory, site cursor, neighbour
// sums, energy and moment registers, counters and sums. Depends on iml_pkg.
`default_nettype none

module iml_datapath import iml_pkg::*; #(
   parameter int LATTICE_SIDE = DEFAULT_LATTICE_SIDE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  iml_cmd_type                 cmd,
   output iml_status_type              status,
   input  logic [ROW_W-1:0]            req_row,
   input  logic [ROW_W-1:0]            req_col,
   input  logic                        req_spin_up,
   input  logic [RND_W-1:0]            req_random_value,
   input  logic [THRESH_W-1:0]         threshold_4,
   input  logic [THRESH_W-1:0]         threshold_8,
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output logic signed [ENERGY_W-1:0]  rsp_energy,
   output logic signed [MOMENT_W-1:0]  rsp_moment,
   output logic [ACC_CNT_W-1:0]        rsp_accepted_count,
   output logic [SWEEP_CNT_W-1:0]      rsp_sweep_count,
   output logic signed [SUM_E_W-1:0]   rsp_sum_energy,
   output logic [SUM_E2_W-1:0]         rsp_sum_energy_sq,
   output logic signed [SUM_M_W-1:0]   rsp_sum_moment,
   output logic [SUM_M2_W-1:0]         rsp_sum_moment_sq,
   output logic [SUM_AM_W-1:0]         rsp_sum_abs_moment
);

   localparam int IDX_W    = $clog2(LATTICE_SIDE);
   localparam int SITES    = LATTICE_SIDE * LATTICE_SIDE;
   localparam int ADDR_W   = $clog2(SITES);
   localparam int ROW_SPAN = 2 ** ROW_W;
   localparam int E_NEED   = $clog2(2 * SITES + 1) + 1;
   localparam int M_NEED   = $clog2(SITES + 1) + 1;
   localparam int EACC_W   = (E_NEED > ENERGY_W + 1) ? E_NEED : ENERGY_W + 1;
   localparam int MACC_W   = (M_NEED > MOMENT_W + 1) ? M_NEED : MOMENT_W + 1;

   localparam logic [IDX_W-1:0]         IDX_MAX = IDX_W'(LATTICE_SIDE - 1);
   localparam logic signed [EACC_W-1:0] E_HI    = EACC_W'(2 ** (ENERGY_W - 1) - 1);
   localparam logic signed [EACC_W-1:0] E_LO    = EACC_W'(-(2 ** (ENERGY_W - 1)));
   localparam logic signed [EACC_W-1:0] E_TWO   = EACC_W'(2);
   localparam logic signed [MACC_W-1:0] M_HI    = MACC_W'(2 ** (MOMENT_W - 1) - 1);
   localparam logic signed [MACC_W-1:0] M_LO    = MACC_W'(-(2 ** (MOMENT_W - 1)));
   localparam logic signed [MACC_W-1:0] M_ONE   = MACC_W'(1);

   logic [IDX_W-1:0] reduce_tab [ROW_SPAN];

   for (genvar gi = 0; gi < ROW_SPAN; gi++) begin : g_reduce
      localparam int Reduced = gi % LATTICE_SIDE;
      assign reduce_tab[gi] = IDX_W'(Reduced);
   end

   logic [IDX_W-1:0]  row_ff, col_ff;
   logic [IDX_W-1:0]  row_nx, row_pv, col_nx, col_pv;
   logic [IDX_W-1:0]  addr_row, addr_col;
   logic [ADDR_W-1:0] lat_addr;
   logic              lattice_ff [SITES];
   logic              q_ff;
   logic              wr_bit;
   logic              mem_wr;
   iml_tag_type       tag_ff;

   logic              spin_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic              s_ff;
   logic              pr_ff;
   logic signed [3:0] nsum_ff;
   logic signed [EACC_W-1:0] e_acc_ff;
   logic signed [MACC_W-1:0] m_acc_ff;

   logic signed [ENERGY_W-1:0] energy_ff;
   logic signed [MOMENT_W-1:0] moment_ff;
   logic                       accepted_ff;
   logic                       rsp_valid_ff;
   logic [ACC_CNT_W-1:0]       acc_cnt_ff;
   logic [SWEEP_CNT_W-1:0]     sweep_cnt_ff;
   logic [SUM_E_W-1:0]         sum_e_ff;
   logic [SUM_E2_W-1:0]        sum_e2_ff;
   logic [SUM_M_W-1:0]         sum_m_ff;
   logic [SUM_M2_W-1:0]        sum_m2_ff;
   logic [SUM_AM_W-1:0]        sum_am_ff;
   logic [E2_W-1:0]            e2_ff;
   logic [M2_W-1:0]            m2_ff;

   logic signed [3:0]          prod;
   logic [5:0]                 de6;
   logic                       flip;
   logic [ENERGY_W:0]          e_step;
   logic [MOMENT_W:0]          m_step;
   logic [ENERGY_W-1:0]        energy_flip_in;
   logic [MOMENT_W-1:0]        moment_flip_in;
   logic signed [ENERGY_W-1:0] energy_walk_in;
   logic signed [MOMENT_W-1:0] moment_walk_in;
   logic signed [EACC_W-1:0]   bond_de;
   logic signed [2*ENERGY_W-1:0] e2_full;
   logic signed [2*MOMENT_W-1:0] m2_full;
   logic [MOMENT_W-1:0]        abs_m;
   logic [SUM_E_W:0]           se_ext;
   logic [SUM_E2_W:0]          se2_ext;
   logic [SUM_M_W:0]           sm_ext;
   logic [SUM_M2_W:0]          sm2_ext;
   logic [SUM_AM_W:0]          sam_ext;
   logic [SUM_E_W-1:0]         sum_e_in;
   logic [SUM_E2_W-1:0]        sum_e2_in;
   logic [SUM_M_W-1:0]         sum_m_in;
   logic [SUM_M2_W-1:0]        sum_m2_in;
   logic [SUM_AM_W-1:0]        sum_am_in;

   assign row_nx = (row_ff == IDX_MAX) ? '0 : row_ff + 1'b1;
   assign row_pv = (row_ff == '0) ? IDX_MAX : row_ff - 1'b1;
   assign col_nx = (col_ff == IDX_MAX) ? '0 : col_ff + 1'b1;
   assign col_pv = (col_ff == '0) ? IDX_MAX : col_ff - 1'b1;

   assign status.cursor_last = (row_ff == IDX_MAX) && (col_ff == IDX_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.walk_init) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.latch) begin
         row_ff <= reduce_tab[req_row];
         col_ff <= reduce_tab[req_col];
      end else if (cmd.cursor_step) begin
         col_ff <= col_nx;
         if (col_ff == IDX_MAX) begin
            row_ff <= row_nx;
         end
      end
   end

   always_comb begin
      addr_row = row_ff;
      addr_col = col_ff;
      unique case (cmd.addr_sel)
         ADR_SITE:  ;
         ADR_RIGHT: addr_col = col_nx;
         ADR_DOWN:  addr_row = row_nx;
         ADR_LEFT:  addr_col = col_pv;
         ADR_UP:    addr_row = row_pv;
         default:   ;
      endcase
   end

   assign lat_addr = ADDR_W'(ADDR_W'(addr_row) * ADDR_W'(LATTICE_SIDE)) + ADDR_W'(addr_col);

   always_comb begin
      case (cmd.wr_sel)
         WR_LOAD: wr_bit = spin_ff;
         WR_FLIP: wr_bit = ~s_ff;
         default: wr_bit = 1'b1;
      endcase
   end

   assign mem_wr = cmd.wr_en && ((cmd.wr_sel != WR_FLIP) || flip);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         lattice_ff[lat_addr] <= wr_bit;
      end
      q_ff <= lattice_ff[lat_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_NONE;
      end else begin
         tag_ff <= cmd.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         spin_ff <= req_spin_up;
         rnd_ff  <= req_random_value;
      end
   end

   assign bond_de = (pr_ff == q_ff) ? ((pr_ff == s_ff) ? -E_TWO : E_TWO) : '0;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         nsum_ff <= '0;
      end else if (tag_ff == TAG_NBR) begin
         nsum_ff <= nsum_ff + (q_ff ? 4'sd1 : -4'sd1);
      end
      if (cmd.walk_init) begin
         e_acc_ff <= '0;
         m_acc_ff <= '0;
      end else if (tag_ff == TAG_BOND) begin
         e_acc_ff <= e_acc_ff + bond_de;
         m_acc_ff <= m_acc_ff + (s_ff ? M_ONE : -M_ONE);
      end
      if (tag_ff == TAG_SITE) begin
         s_ff <= q_ff;
      end
      if (tag_ff == TAG_PAIR) begin
         pr_ff <= q_ff;
      end
   end

   // The energy change is twice the spin times the neighbour sum.
   assign prod = s_ff ? nsum_ff : -nsum_ff;
   assign de6  = {prod[3], prod, 1'b0};

   always_comb begin
      if (prod <= 4'sd0) begin
         flip = 1'b1;
      end else if (prod == 4'sd2) begin
         flip = {1'b0, rnd_ff} < threshold_4;
      end else if (prod == 4'sd4) begin
         flip = {1'b0, rnd_ff} < threshold_8;
      end else begin
         flip = 1'b0;
      end
   end

   always_comb begin
      e_step = {energy_ff[ENERGY_W-1], energy_ff}
             + {{(ENERGY_W-5){de6[5]}}, de6};
      if (e_step[ENERGY_W] != e_step[ENERGY_W-1]) begin
         energy_flip_in = e_step[ENERGY_W] ? {1'b1, {(ENERGY_W-1){1'b0}}}
                                           : {1'b0, {(ENERGY_W-1){1'b1}}};
      end else begin
         energy_flip_in = e_step[ENERGY_W-1:0];
      end
      m_step = {moment_ff[MOMENT_W-1], moment_ff}
             + (s_ff ? {{(MOMENT_W-1){1'b1}}, 2'b10} : (MOMENT_W+1)'(2));
      if (m_step[MOMENT_W] != m_step[MOMENT_W-1]) begin
         moment_flip_in = m_step[MOMENT_W] ? {1'b1, {(MOMENT_W-1){1'b0}}}
                                           : {1'b0, {(MOMENT_W-1){1'b1}}};
      end else begin
         moment_flip_in = m_step[MOMENT_W-1:0];
      end
   end

   always_comb begin
      if (e_acc_ff > E_HI) begin
         energy_walk_in = E_HI[ENERGY_W-1:0];
      end else if (e_acc_ff < E_LO) begin
         energy_walk_in = E_LO[ENERGY_W-1:0];
      end else begin
         energy_walk_in = e_acc_ff[ENERGY_W-1:0];
      end
      if (m_acc_ff > M_HI) begin
         moment_walk_in = M_HI[MOMENT_W-1:0];
      end else if (m_acc_ff < M_LO) begin
         moment_walk_in = M_LO[MOMENT_W-1:0];
      end else begin
         moment_walk_in = m_acc_ff[MOMENT_W-1:0];
      end
   end

   assign e2_full = energy_ff * energy_ff;
   assign m2_full = moment_ff * moment_ff;
   assign abs_m   = moment_ff[MOMENT_W-1] ? (~moment_ff + 1'b1) : moment_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep_square) begin
         e2_ff <= e2_full[E2_W-1:0];
         m2_ff <= m2_full[M2_W-1:0];
      end
   end

   always_comb begin
      se_ext  = {sum_e_ff[SUM_E_W-1], sum_e_ff}
              + {{(SUM_E_W+1-ENERGY_W){energy_ff[ENERGY_W-1]}}, energy_ff};
      sm_ext  = {sum_m_ff[SUM_M_W-1], sum_m_ff}
              + {{(SUM_M_W+1-MOMENT_W){moment_ff[MOMENT_W-1]}}, moment_ff};
      se2_ext = {1'b0, sum_e2_ff} + {{(SUM_E2_W+1-E2_W){1'b0}}, e2_ff};
      sm2_ext = {1'b0, sum_m2_ff} + {{(SUM_M2_W+1-M2_W){1'b0}}, m2_ff};
      sam_ext = {1'b0, sum_am_ff} + {{(SUM_AM_W+1-MOMENT_W){1'b0}}, abs_m};

      if (se_ext[SUM_E_W] != se_ext[SUM_E_W-1]) begin
         sum_e_in = se_ext[SUM_E_W] ? {1'b1, {(SUM_E_W-1){1'b0}}}
                                    : {1'b0, {(SUM_E_W-1){1'b1}}};
      end else begin
         sum_e_in = se_ext[SUM_E_W-1:0];
      end
      if (sm_ext[SUM_M_W] != sm_ext[SUM_M_W-1]) begin
         sum_m_in = sm_ext[SUM_M_W] ? {1'b1, {(SUM_M_W-1){1'b0}}}
                                    : {1'b0, {(SUM_M_W-1){1'b1}}};
      end else begin
         sum_m_in = sm_ext[SUM_M_W-1:0];
      end
      sum_e2_in = se2_ext[SUM_E2_W] ? '1 : se2_ext[SUM_E2_W-1:0];
      sum_m2_in = sm2_ext[SUM_M2_W] ? '1 : sm2_ext[SUM_M2_W-1:0];
      sum_am_in = sam_ext[SUM_AM_W] ? '1 : sam_ext[SUM_AM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         moment_ff    <= '0;
         accepted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_cnt_ff   <= '0;
         sweep_cnt_ff <= '0;
         sum_e_ff     <= '0;
         sum_e2_ff    <= '0;
         sum_m_ff     <= '0;
         sum_m2_ff    <= '0;
         sum_am_ff    <= '0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.latch || cmd.walk_init) begin
            accepted_ff <= 1'b0;
         end else if (cmd.flip_commit) begin
            accepted_ff <= flip;
         end
         if (cmd.flip_commit && flip) begin
            energy_ff <= energy_flip_in;
            moment_ff <= moment_flip_in;
            if (acc_cnt_ff != '1) begin
               acc_cnt_ff <= acc_cnt_ff + 1'b1;
            end
         end
         if (cmd.walk_commit) begin
            energy_ff    <= energy_walk_in;
            moment_ff    <= moment_walk_in;
            acc_cnt_ff   <= '0;
            sweep_cnt_ff <= '0;
            sum_e_ff     <= '0;
            sum_e2_ff    <= '0;
            sum_m_ff     <= '0;
            sum_m2_ff    <= '0;
            sum_am_ff    <= '0;
         end
         if (cmd.sweep_commit && (sweep_cnt_ff != '1)) begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
            sum_e_ff     <= sum_e_in;
            sum_e2_ff    <= sum_e2_in;
            sum_m_ff     <= sum_m_in;
            sum_m2_ff    <= sum_m2_in;
            sum_am_ff    <= sum_am_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_energy         = energy_ff;
   assign rsp_moment         = moment_ff;
   assign rsp_accepted_count = acc_cnt_ff;
   assign rsp_sweep_count    = sweep_cnt_ff;
   assign rsp_sum_energy     = sum_e_ff;
   assign rsp_sum_energy_sq  = sum_e2_ff;
   assign rsp_sum_moment     = sum_m_ff;
   assign rsp_sum_moment_sq  = sum_m2_ff;
   assign rsp_sum_abs_moment = sum_am_ff;

endmodule

`default_nettype wire

[sv/ising_metropolis_lattice.sv]
// Top level of the Metropolis lattice block: controller, datapath and
// threshold registers. Depends on iml_pkg, iml_ctrl, iml_datapath and iml_csr.
//
// A request is taken at a rising edge with start high and busy low. It loads
// one spin, starts a run (measures energy and moment and clears the counters
// and sums), attempts a flip at one site, or closes a sweep. Every request
// gives one response, shown for a single cycle with rsp_valid high and taken
// at the edge that ends that cycle; the receiver cannot hold it off.
// Busy stays high from acceptance until the response shows, so requests are
// taken one at a time.
// A flip attempt reads the site and its four neighbours one after another
// through the single read port of the spin memory, then writes the flipped
// site back if the flip is accepted. The start walk reads three spins per
// site through that same port. After reset the spin memory is set to all up
// by a clearing pass, during which busy is high; threshold writes on the
// APB-style port are taken at any time.
`default_nettype none

module ising_metropolis_lattice import iml_pkg::*; #(
   parameter int LATTICE_SIDE = DEFAULT_LATTICE_SIDE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [KIND_W-1:0]           req_kind,
   input  logic [ROW_W-1:0]            req_row,
   input  logic [ROW_W-1:0]            req_col,
   input  logic                        req_spin_up,
   input  logic [RND_W-1:0]            req_random_value,
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output logic signed [ENERGY_W-1:0]  rsp_energy,
   output logic signed [MOMENT_W-1:0]  rsp_moment,
   output logic [ACC_CNT_W-1:0]        rsp_accepted_count,
   output logic [SWEEP_CNT_W-1:0]      rsp_sweep_count,
   output logic signed [SUM_E_W-1:0]   rsp_sum_energy,
   output logic [SUM_E2_W-1:0]         rsp_sum_energy_sq,
   output logic signed [SUM_M_W-1:0]   rsp_sum_moment,
   output logic [SUM_M2_W-1:0]         rsp_sum_moment_sq,
   output logic [SUM_AM_W-1:0]         rsp_sum_abs_moment,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_W-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]       pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   iml_cmd_type         cmd;
   iml_status_type      status;
   logic [THRESH_W-1:0] threshold_4;
   logic [THRESH_W-1:0] threshold_8;

   iml_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .threshold_4 (threshold_4),
      .threshold_8 (threshold_8)
   );

   iml_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   iml_datapath #(
      .LATTICE_SIDE (LATTICE_SIDE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_spin_up        (req_spin_up),
      .req_random_value   (req_random_value),
      .threshold_4        (threshold_4),
      .threshold_8        (threshold_8),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_energy         (rsp_energy),
      .rsp_moment         (rsp_moment),
      .rsp_accepted_count (rsp_accepted_count),
      .rsp_sweep_count    (rsp_sweep_count),
      .rsp_sum_energy     (rsp_sum_energy),
      .rsp_sum_energy_sq  (rsp_sum_energy_sq),
      .rsp_sum_moment     (rsp_sum_moment),
      .rsp_sum_moment_sq  (rsp_sum_moment_sq),
      .rsp_sum_abs_moment (rsp_sum_abs_moment)
   );

endmodule

`default_nettype wire

[sv/iml_checker.sv]
// Port-level checker of the Metropolis lattice block, bound to the top level.
// Depends on iml_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module iml_checker import iml_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_accepted,
   input logic [ACC_CNT_W-1:0] rsp_accepted_count
);

   // A request that has been taken keeps the block busy in the next cycle.
   `IML_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy, "request not held busy")

   // A response only follows work, never an idle cycle.
   `IML_ASSERT(a_rsp_after_work, clock, reset, !rsp_valid || $past(busy), "response without request")

   // Each response is a single-cycle strobe.
   `IML_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response repeated")

   // An accepted flip is always counted.
   `IML_ASSERT(a_flip_counted, clock, reset, !(rsp_valid && rsp_accepted) || (rsp_accepted_count != '0), "accepted flip not counted")

endmodule

bind ising_metropolis_lattice iml_checker u_checker (.*);

`default_nettype wire
